// ===== rtl/bcc_pkg.sv =====
// Package for the charge-current PID block: payload and config types,
// field codes, queue depth and ramp constants. No dependencies.
package bcc_pkg;

  // Soft-start ramp: reference rises by one every RAMP_TICKS ticks
  localparam int RAMP_TICKS = 50;
  localparam int TICK_W     = $clog2(RAMP_TICKS + 1);

  // Front-to-back queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Input item kinds
  localparam logic KIND_CONV = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Converter channels
  localparam logic [2:0] CH_BUCK    = 3'd0;
  localparam logic [2:0] CH_SPARE   = 3'd1;
  localparam logic [2:0] CH_CELL    = 3'd2;
  localparam logic [2:0] CH_CURRENT = 3'd3;
  localparam logic [2:0] CH_SUPPLY  = 3'd7;

  // Charge phases
  localparam logic [1:0] PH_ARMED    = 2'd0;
  localparam logic [1:0] PH_CHARGING = 2'd1;
  localparam logic [1:0] PH_DONE     = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_SUPPLY_MIN   = 3'd0;
  localparam logic [2:0] CFG_CELL_RESTART = 3'd1;
  localparam logic [2:0] CFG_CELL_FULL    = 3'd2;
  localparam logic [2:0] CFG_END_CURRENT  = 3'd3;
  localparam logic [2:0] CFG_CURR_LIMIT   = 3'd4;
  localparam logic [2:0] CFG_GAIN_P       = 3'd5;
  localparam logic [2:0] CFG_GAIN_I       = 3'd6;
  localparam logic [2:0] CFG_GAIN_D       = 3'd7;

  localparam logic [9:0] PWM_MAX = 10'd1023;

  typedef struct packed {
    logic       kind;
    logic [9:0] sample;
  } bcc_in_t;

  typedef struct packed {
    logic [9:0] duty;
    logic [2:0] next_channel;
    logic       adc_start;
    logic [1:0] charge_state;
    logic       lion_path_on;
  } bcc_out_t;

  typedef struct packed {
    logic [9:0]  supply_min;
    logic [9:0]  cell_restart_level;
    logic [9:0]  cell_full_level;
    logic [9:0]  end_current;
    logic [9:0]  current_limit;
    logic [23:0] gain_p;
    logic [23:0] gain_i;
    logic [23:0] gain_d;
  } bcc_cfg_t;

  // Classified queue entry
  typedef struct packed {
    logic       is_tick;
    logic [9:0] sample;
  } bcc_op_t;

  // PID operands issued by the back end
  typedef struct packed {
    logic        valid;
    logic [10:0] err;
    logic [23:0] sum;
    logic [11:0] diff;
  } bcc_pid_req_t;

  typedef struct packed {
    logic       valid;
    logic [9:0] pwm;
  } bcc_pid_rsp_t;

endpackage

// ===== rtl/bcc_front.sv =====
// Front end: accepts input transactions, classifies them and queues them
// for the back end. Depends on bcc_pkg.
module bcc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bcc_pkg::bcc_in_t in_data,
  output logic             q_valid,
  output bcc_pkg::bcc_op_t q_data,
  input  logic             q_pop
);
  import bcc_pkg::*;

  bcc_op_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               push;
  bcc_op_t            op;

  // Classify the incoming transaction
  always_comb begin
    op.is_tick = (in_data.kind == KIND_TICK);
    op.sample  = in_data.sample;
  end

  assign in_stall = (count_r == Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_data   = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store queue entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= op;
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> count_r != '0)
    else $error("pop from empty queue");

  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

// ===== rtl/bcc_pid.sv =====
// PID arithmetic: two-stage pipeline of gain products and their clamped
// sum into a PWM compare value. Depends on bcc_pkg.
module bcc_pid (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bcc_pkg::bcc_cfg_t     cfg,
  input  bcc_pkg::bcc_pid_req_t req,
  output bcc_pkg::bcc_pid_rsp_t rsp
);
  import bcc_pkg::*;

  logic               mul_valid_r;
  logic signed [34:0] prod_p_r;
  logic signed [47:0] prod_i_r;
  logic signed [35:0] prod_d_r;
  logic signed [49:0] u;
  logic [9:0]         pwm_nxt;
  bcc_pid_rsp_t       rsp_r;

  // Stage 1: gain products
  always_ff @(posedge clk) begin
    prod_p_r <= $signed(cfg.gain_p) * $signed(req.err);
    prod_i_r <= $signed(cfg.gain_i) * $signed(req.sum);
    prod_d_r <= $signed(cfg.gain_d) * $signed(req.diff);
  end

  // Stage 2: sum in Q16, clamp to the PWM range
  always_comb begin
    u = {{15{prod_p_r[34]}}, prod_p_r}
      + {{2{prod_i_r[47]}}, prod_i_r}
      + {{14{prod_d_r[35]}}, prod_d_r};
    if (u[49]) begin
      pwm_nxt = '0;
    end else if (|u[48:26]) begin
      pwm_nxt = PWM_MAX;
    end else begin
      pwm_nxt = u[25:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      rsp_r.valid <= 1'b0;
    end else begin
      mul_valid_r <= req.valid;
      rsp_r.valid <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    rsp_r.pwm <= pwm_nxt;
  end

  assign rsp = rsp_r;

endmodule

// ===== rtl/bcc_ctrl.sv =====
// Back end: sequences each queued transaction, holds the charger state,
// runs the charge state machine and drives the output register.
// Depends on bcc_pkg.
module bcc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bcc_pkg::bcc_cfg_t     cfg,
  input  logic                  q_valid,
  input  bcc_pkg::bcc_op_t      q_data,
  output logic                  q_pop,
  output bcc_pkg::bcc_pid_req_t pid_req,
  input  bcc_pkg::bcc_pid_rsp_t pid_rsp,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bcc_pkg::bcc_out_t     out_data
);
  import bcc_pkg::*;

  localparam logic [1:0] ST_EXEC = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [2:0]        mux_r, mux_nxt;
  logic [9:0]        cell_r, cell_nxt;
  logic [9:0]        supply_r, supply_nxt;
  logic [9:0]        current_r, current_nxt;
  logic [9:0]        ref_r, ref_nxt;
  logic [TICK_W-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [23:0]       err_sum_r, err_sum_nxt;
  logic [10:0]       last_err_r, last_err_nxt;
  logic [9:0]        pwm_r, pwm_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic              path_r, path_nxt;
  logic              tick_item_r, tick_item_nxt;
  bcc_pid_req_t      req_r, req_nxt;
  logic              out_valid_r, out_valid_nxt;
  bcc_out_t          out_data_r, out_data_nxt;

  logic        out_free;
  logic        out_load;
  logic [9:0]  cur_new;
  logic [10:0] err;
  logic [24:0] sum_wide;
  logic [23:0] sum_sat;
  logic [11:0] diff;
  logic [1:0]  ph_tmp;
  logic [9:0]  pwm_cur;

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_DONE) && out_free;
  assign q_pop    = (state_r == ST_EXEC) && q_valid;
  assign pwm_cur  = pid_rsp.valid ? pid_rsp.pwm : pwm_r;

  // PID operands from the freshly stored current reading
  always_comb begin
    cur_new  = (mux_r == CH_CURRENT) ? q_data.sample : current_r;
    err      = {1'b0, ref_r} - {1'b0, cur_new};
    sum_wide = {err_sum_r[23], err_sum_r} + {{14{err[10]}}, err};
    if (sum_wide[24] != sum_wide[23]) begin
      sum_sat = sum_wide[24] ? 24'h800000 : 24'h7FFFFF;
    end else begin
      sum_sat = sum_wide[23:0];
    end
    diff = {err[10], err} - {last_err_r[10], last_err_r};
  end

  always_comb begin
    state_nxt     = state_r;
    mux_nxt       = mux_r;
    cell_nxt      = cell_r;
    supply_nxt    = supply_r;
    current_nxt   = current_r;
    ref_nxt       = ref_r;
    tick_cnt_nxt  = tick_cnt_r;
    err_sum_nxt   = err_sum_r;
    last_err_nxt  = last_err_r;
    pwm_nxt       = pid_rsp.valid ? pid_rsp.pwm : pwm_r;
    phase_nxt     = phase_r;
    path_nxt      = path_r;
    tick_item_nxt = tick_item_r;
    req_nxt       = req_r;
    req_nxt.valid = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ph_tmp        = phase_r;

    case (state_r)
      ST_EXEC: begin
        if (q_valid) begin
          tick_item_nxt = q_data.is_tick;
          state_nxt     = ST_DONE;
          if (q_data.is_tick) begin
            // Advance the ramp counter; step the reference on wrap while below the current limit
            if (tick_cnt_r == TICK_W'(RAMP_TICKS - 1)) begin
              tick_cnt_nxt = '0;
              if (ref_r < cfg.current_limit) begin
                ref_nxt = ref_r + 1'b1;
              end
            end else begin
              tick_cnt_nxt = tick_cnt_r + 1'b1;
            end
          end else begin
            // Store the cell, current or supply reading and step the converter mux
            case (mux_r)
              CH_BUCK:    mux_nxt = CH_SPARE;
              CH_SPARE:   mux_nxt = CH_CELL;
              CH_CELL: begin
                cell_nxt = q_data.sample;
                mux_nxt  = CH_CURRENT;
              end
              CH_CURRENT: begin
                current_nxt = q_data.sample;
                mux_nxt     = CH_SUPPLY;
              end
              CH_SUPPLY: begin
                supply_nxt = q_data.sample;
                mux_nxt    = CH_BUCK;
              end
              default:    mux_nxt = CH_BUCK;
            endcase
            if (phase_r == PH_CHARGING) begin
              req_nxt.valid = 1'b1;
              req_nxt.err   = err;
              req_nxt.sum   = sum_sat;
              req_nxt.diff  = diff;
              err_sum_nxt   = sum_sat;
              last_err_nxt  = err;
              state_nxt     = ST_MUL;
            end
          end
        end
      end
      ST_MUL: state_nxt = ST_ADD;
      ST_ADD: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          // Charge state machine, then publish the result
          if (supply_r > cfg.supply_min) begin
            if (cell_r < cfg.cell_restart_level && phase_r == PH_DONE) begin
              ph_tmp = PH_ARMED;
            end
            if (cell_r < cfg.cell_full_level && ph_tmp == PH_ARMED) begin
              phase_nxt    = PH_CHARGING;
              path_nxt     = 1'b1;
              err_sum_nxt  = '0;
              last_err_nxt = '0;
              ref_nxt      = '0;
            end else if (current_r < cfg.end_current) begin
              phase_nxt = PH_DONE;
              path_nxt  = 1'b0;
            end else begin
              phase_nxt = ph_tmp;
            end
          end
          out_valid_nxt             = 1'b1;
          out_data_nxt.duty         = pwm_cur;
          out_data_nxt.next_channel = mux_r;
          out_data_nxt.adc_start    = tick_item_r;
          out_data_nxt.charge_state = phase_nxt;
          out_data_nxt.lion_path_on = path_nxt;
          state_nxt                 = ST_EXEC;
        end
      end
      default: state_nxt = ST_EXEC;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      mux_r       <= CH_CURRENT;
      cell_r      <= '0;
      supply_r    <= '0;
      current_r   <= '0;
      ref_r       <= 10'd100;
      tick_cnt_r  <= '0;
      err_sum_r   <= '0;
      last_err_r  <= '0;
      pwm_r       <= PWM_MAX;
      phase_r     <= PH_DONE;
      path_r      <= 1'b0;
      req_r.valid <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mux_r       <= mux_nxt;
      cell_r      <= cell_nxt;
      supply_r    <= supply_nxt;
      current_r   <= current_nxt;
      ref_r       <= ref_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      err_sum_r   <= err_sum_nxt;
      last_err_r  <= last_err_nxt;
      pwm_r       <= pwm_nxt;
      phase_r     <= phase_nxt;
      path_r      <= path_nxt;
      req_r.valid <= req_nxt.valid;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tick_item_r <= tick_item_nxt;
    req_r.err   <= req_nxt.err;
    req_r.sum   <= req_nxt.sum;
    req_r.diff  <= req_nxt.diff;
    out_data_r  <= out_data_nxt;
  end

  assign pid_req   = req_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_path_phase: assert property (@(posedge clk) disable iff (!rst_n)
    path_r == (phase_r == PH_CHARGING))
    else $error("path enable out of step with charge phase");

  a_pop_exec: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_EXEC)
    else $error("queue popped while a transaction is in flight");

  a_rsp_done: assert property (@(posedge clk) disable iff (!rst_n)
    pid_rsp.valid |-> state_r == ST_DONE)
    else $error("PID result arrived outside the done state");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

// ===== rtl/battery_charge_current_pid.sv =====
// Constant-current Li-ion charger with soft-start reference and PID loop.
//
// Input channel (in_valid / in_stall / in_data): one transaction is either
// a 1 ms tick or a converter result for the currently selected channel.
// Result channel (out_valid / out_stall / out_data): exactly one result per
// input transaction, in order: PWM duty, next converter channel, conversion
// request flag, charge phase and path enable.
// Configuration port (cfg_we / cfg_index / cfg_wdata): thresholds, current
// limit and signed Q8.16 gains; write only while no transaction is pending.
// A tick, or a conversion outside the charging phase, passes from queue
// head through the execute and done states to the result register; a
// conversion while charging also waits in the multiply and add states for
// the two-stage gain multiply and sum of the PID unit. The back end takes
// one transaction at a time; a 4-entry queue lets inputs be taken meanwhile.
// Reset (synchronous, rst_n low) empties the queue, loads the default
// configuration and returns the charger to the done phase with full duty.
// A stalled receiver holds the result register; the back end then waits
// and the queue fills until in_stall rises.
module battery_charge_current_pid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bcc_pkg::bcc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bcc_pkg::bcc_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_wdata
);
  import bcc_pkg::*;

  bcc_cfg_t     cfg_r;
  logic         q_valid;
  bcc_op_t      q_data;
  logic         q_pop;
  bcc_pid_req_t pid_req;
  bcc_pid_rsp_t pid_rsp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.supply_min         <= 10'd359;
      cfg_r.cell_restart_level <= 10'd860;
      cfg_r.cell_full_level    <= 10'd860;
      cfg_r.end_current        <= 10'd92;
      cfg_r.current_limit      <= 10'd614;
      cfg_r.gain_p             <= 24'hFFDFF6;
      cfg_r.gain_i             <= 24'hFFF707;
      cfg_r.gain_d             <= 24'hFFEA45;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SUPPLY_MIN:   cfg_r.supply_min         <= cfg_wdata[9:0];
        CFG_CELL_RESTART: cfg_r.cell_restart_level <= cfg_wdata[9:0];
        CFG_CELL_FULL:    cfg_r.cell_full_level    <= cfg_wdata[9:0];
        CFG_END_CURRENT:  cfg_r.end_current        <= cfg_wdata[9:0];
        CFG_CURR_LIMIT:   cfg_r.current_limit      <= cfg_wdata[9:0];
        CFG_GAIN_P:       cfg_r.gain_p             <= cfg_wdata;
        CFG_GAIN_I:       cfg_r.gain_i             <= cfg_wdata;
        CFG_GAIN_D:       cfg_r.gain_d             <= cfg_wdata;
        default:          cfg_r.supply_min         <= cfg_r.supply_min;
      endcase
    end
  end

  bcc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  bcc_pid u_pid (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .req   (pid_req),
    .rsp   (pid_rsp)
  );

  bcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .pid_req   (pid_req),
    .pid_rsp   (pid_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== test/tb_battery_charge_current_pid.sv =====
// Testbench for battery_charge_current_pid: random and directed transactions with
// a scoreboard class that predicts every result and compares it field by field.
// Depends on bcc_pkg and the battery_charge_current_pid RTL only.
module tb_battery_charge_current_pid;
  import bcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 120;
  localparam int DRAIN_CYCLES   = 16;

  // Predicts charger outputs and keeps the results still owed by the block
  class charger_scoreboard;
    logic [9:0]         supply_min, restart_level, full_level, end_cur, limit;
    logic signed [23:0] kp, ki, kd;
    logic [2:0]         mux;
    logic [9:0]         cell_lvl, supply, current, buck, ref_level, duty;
    logic [5:0]         ticks;
    logic signed [23:0] err_sum;
    logic signed [10:0] prev_err;
    logic [1:0]         chg_phase;
    logic               path_on;
    bcc_out_t           expected_results[$];
    int                 errors;

    function new();
      supply_min    = 10'd359;
      restart_level = 10'd860;
      full_level    = 10'd860;
      end_cur       = 10'd92;
      limit         = 10'd614;
      kp            = -24'sd8202;
      ki            = -24'sd2297;
      kd            = -24'sd5563;
      mux           = CH_CURRENT;
      cell_lvl      = '0;
      supply        = '0;
      current       = '0;
      buck          = '0;
      ref_level     = 10'd100;
      ticks         = '0;
      err_sum       = '0;
      prev_err      = '0;
      duty          = PWM_MAX;
      chg_phase     = PH_DONE;
      path_on       = 1'b0;
      errors        = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [23:0] v);
      case (idx)
        CFG_SUPPLY_MIN:   supply_min    = v[9:0];
        CFG_CELL_RESTART: restart_level = v[9:0];
        CFG_CELL_FULL:    full_level    = v[9:0];
        CFG_END_CURRENT:  end_cur       = v[9:0];
        CFG_CURR_LIMIT:   limit         = v[9:0];
        CFG_GAIN_P:       kp            = v;
        CFG_GAIN_I:       ki            = v;
        CFG_GAIN_D:       kd            = v;
        default: ;
      endcase
    endfunction

    // PID on the current error; exact Q16 sum, then clamp to the PWM range
    function void run_current_loop();
      longint e, acc, u, q;
      e   = longint'(ref_level) - longint'(current);
      acc = longint'(err_sum) + e;
      if (acc > 64'sd8388607) acc = 64'sd8388607;
      if (acc < -64'sd8388608) acc = -64'sd8388608;
      err_sum = acc[23:0];
      u = longint'(kp) * e + longint'(ki) * longint'(err_sum)
          + longint'(kd) * (e - longint'(prev_err));
      if (u < 0) begin
        duty = '0;
      end else begin
        q = u / 65536;
        duty = (q > 1023) ? PWM_MAX : q[9:0];
      end
      prev_err = e[10:0];
    endfunction

    // Charge phase machine, evaluated only with a healthy supply
    function void evaluate_charge_phase();
      if (supply > supply_min) begin
        if (cell_lvl < restart_level && chg_phase == PH_DONE) chg_phase = PH_ARMED;
        if (cell_lvl < full_level && chg_phase == PH_ARMED) begin
          chg_phase = PH_CHARGING;
          path_on   = 1'b1;
          err_sum   = '0;
          prev_err  = '0;
          ref_level = '0;
        end else if (current < end_cur) begin
          chg_phase = PH_DONE;
          path_on   = 1'b0;
        end
      end
    endfunction

    // Advance the prediction by one accepted input transaction
    function void note_transaction(bcc_in_t item);
      bcc_out_t exp_res;
      if (item.kind == KIND_TICK) begin
        ticks = (ticks == 6'(RAMP_TICKS - 1)) ? '0 : ticks + 6'd1;
        if (ticks == '0 && ref_level < limit) ref_level = ref_level + 10'd1;
      end else begin
        case (mux)
          CH_BUCK:    begin buck = item.sample;     mux = CH_SPARE;   end
          CH_SPARE:   mux = CH_CELL;
          CH_CELL:    begin cell_lvl = item.sample; mux = CH_CURRENT; end
          CH_CURRENT: begin current = item.sample;  mux = CH_SUPPLY;  end
          CH_SUPPLY:  begin supply = item.sample;   mux = CH_BUCK;    end
          default:    mux = CH_BUCK;
        endcase
        if (chg_phase == PH_CHARGING) run_current_loop();
      end
      evaluate_charge_phase();
      exp_res.duty         = duty;
      exp_res.next_channel = mux;
      exp_res.adc_start    = (item.kind == KIND_TICK);
      exp_res.charge_state = chg_phase;
      exp_res.lion_path_on = path_on;
      expected_results.push_back(exp_res);
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_transaction(bcc_out_t got);
      bcc_out_t exp_res;
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing expected: %h", got));
      end else begin
        exp_res = expected_results.pop_front();
        if (got.duty !== exp_res.duty)
          report($sformatf("duty %0d, expected %0d", got.duty, exp_res.duty));
        if (got.next_channel !== exp_res.next_channel)
          report($sformatf("next_channel %0d, expected %0d",
                           got.next_channel, exp_res.next_channel));
        if (got.adc_start !== exp_res.adc_start)
          report($sformatf("adc_start %0d, expected %0d", got.adc_start, exp_res.adc_start));
        if (got.charge_state !== exp_res.charge_state)
          report($sformatf("charge_state %0d, expected %0d",
                           got.charge_state, exp_res.charge_state));
        if (got.lion_path_on !== exp_res.lion_path_on)
          report($sformatf("lion_path_on %0d, expected %0d",
                           got.lion_path_on, exp_res.lion_path_on));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  bcc_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  bcc_out_t    out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_wdata;

  logic        hold_req;
  logic        hold_served;
  logic        calm;
  logic        sender_gaps;
  int          idle_cycles = 0;

  charger_scoreboard sb;

  battery_charge_current_pid uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic bcc_in_t item_of(logic kind, logic [9:0] sample);
    bcc_in_t it;
    it.kind   = kind;
    it.sample = sample;
    return it;
  endfunction

  // Mostly well-formed conversions for the channel the mux will store, some noise
  function automatic bcc_in_t make_item(int tick_pct);
    bcc_in_t    it;
    int         roll;
    logic [9:0] s;
    roll = $urandom_range(0, 99);
    s    = 10'($urandom);
    if (roll < 10) begin
      it = item_of(1'($urandom), s);
    end else if (roll < 10 + tick_pct) begin
      it = item_of(KIND_TICK, s);
    end else begin
      case (sb.mux)
        CH_SUPPLY:
          if (sb.supply_min != 10'd1023 && $urandom_range(0, 99) < 85)
            s = 10'($urandom_range(int'(sb.supply_min) + 1, 1023));
        CH_CELL:
          if (sb.full_level != 10'd0 && $urandom_range(0, 99) < 80)
            s = 10'($urandom_range(0, int'(sb.full_level) - 1));
        CH_CURRENT:
          if ($urandom_range(0, 99) < 85)
            s = 10'($urandom_range(int'(sb.end_cur), 1023));
        default: ;
      endcase
      it = item_of(KIND_CONV, s);
    end
    return it;
  endfunction

  // Offer one transaction, hold it until accepted, then maybe go quiet
  task automatic send(bcc_in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transaction(item);
    if (sender_gaps && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic run_random(int count, int tick_pct);
    for (int i = 0; i < count; i++) send(make_item(tick_pct));
  endtask

  // Drain every owed result, then let the back end settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [23:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_register(idx, v);
  endtask

  task automatic apply_settings(logic [9:0] smin, logic [9:0] restart, logic [9:0] full,
                                logic [9:0] endc, logic [9:0] lim,
                                logic [23:0] gp, logic [23:0] gi, logic [23:0] gd);
    wait_idle();
    write_register(CFG_SUPPLY_MIN, 24'(smin));
    write_register(CFG_CELL_RESTART, 24'(restart));
    write_register(CFG_CELL_FULL, 24'(full));
    write_register(CFG_END_CURRENT, 24'(endc));
    write_register(CFG_CURR_LIMIT, 24'(lim));
    write_register(CFG_GAIN_P, gp);
    write_register(CFG_GAIN_I, gi);
    write_register(CFG_GAIN_D, gd);
    cfg_we <= 1'b0;
  endtask

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_transaction(out_data);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts, quiet stretches, one long hold-off
  initial begin
    out_stall   = 1'b0;
    hold_served = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_SUPPLY_MIN;
    cfg_wdata   = '0;
    hold_req    = 1'b0;
    calm        = 1'b0;
    sender_gaps = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ticks ignore the sample; mux starts at the current channel
    send(item_of(KIND_TICK, 10'd1023));
    send(item_of(KIND_TICK, 10'd0));
    send(item_of(KIND_CONV, 10'd1023));  // current full scale
    send(item_of(KIND_CONV, 10'd1023));  // supply high, empty cell: start charging
    send(item_of(KIND_CONV, 10'd0));     // buck, first PID run on a negative error
    send(item_of(KIND_CONV, 10'd1023));  // spare channel stores nothing
    send(item_of(KIND_CONV, 10'd0));     // cell empty
    send(item_of(KIND_CONV, 10'd0));     // current zero: charging ends
    send(item_of(KIND_CONV, 10'd0));     // supply lost: charge logic frozen
    send(item_of(KIND_CONV, 10'd512));
    send(item_of(KIND_CONV, 10'd5));
    send(item_of(KIND_CONV, 10'd1023));  // cell full
    send(item_of(KIND_CONV, 10'd1023));
    send(item_of(KIND_CONV, 10'd360));   // supply just above its minimum
    send(item_of(KIND_CONV, 10'd0));
    send(item_of(KIND_CONV, 10'd0));
    send(item_of(KIND_CONV, 10'd1023));  // cell full
    send(item_of(KIND_CONV, 10'd91));    // current just under end level
    send(item_of(KIND_CONV, 10'd359));   // supply equal to minimum: no evaluation
    send(item_of(KIND_TICK, 10'd512));
    send(item_of(KIND_CONV, 10'd1));
    send(item_of(KIND_CONV, 10'd1022));
    send(item_of(KIND_CONV, 10'd859));   // cell just under full level
    send(item_of(KIND_CONV, 10'd92));    // current at end level
    send(item_of(KIND_CONV, 10'd1023));

    // Widest thresholds and extreme gains
    apply_settings(10'd0, 10'd1023, 10'd1023, 10'd0, 10'd1023,
                   24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    run_random(120, 20);

    // Charge logic disabled, zero ceiling and gains; fill the block under a long stall
    apply_settings(10'd1023, 10'd0, 10'd0, 10'd1023, 10'd0, 24'h0, 24'h0, 24'h0);
    sender_gaps = 1'b0;
    hold_req <= 1'b1;
    run_random(30, 20);
    sender_gaps = 1'b1;
    run_random(90, 20);

    // Random thresholds, low ceiling, moderate gains
    apply_settings(10'($urandom_range(0, 600)), 10'($urandom_range(200, 1023)),
                   10'($urandom_range(200, 1023)), 10'($urandom_range(0, 200)),
                   10'($urandom_range(0, 5)),
                   24'(int'($urandom_range(0, 60000)) - 30000),
                   24'(int'($urandom_range(0, 60000)) - 30000),
                   24'(int'($urandom_range(0, 60000)) - 30000));
    run_random(130, 50);

    // Default thresholds, ceiling of two, gains over the full range
    apply_settings(10'd359, 10'd860, 10'd860, 10'd92, 10'd2,
                   24'($urandom), 24'($urandom), 24'($urandom));
    run_random(150, 45);

    // Back to defaults, no idling on either side
    apply_settings(10'd359, 10'd860, 10'd860, 10'd92, 10'd614,
                   24'(-8202), 24'(-2297), 24'(-5563));
    calm = 1'b1;
    run_random(150, 30);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
